@@ hw/rtl/oetb_pkg.sv @@
// Shared types and constants of the overwriting event trace buffer.
`timescale 1ns / 1ps
package oetb_pkg;

	// Default ring depth.
	localparam int EVENT_DEPTH_DEF = 64;

	// Width of the stored_count field on the result channel.
	localparam int COUNT_OUT_W = 7;

	// Request kinds.
	localparam logic [2:0] KIND_RECORD = 3'd0;
	localparam logic [2:0] KIND_ARM    = 3'd1;
	localparam logic [2:0] KIND_DISARM = 3'd2;
	localparam logic [2:0] KIND_DUMP   = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	// One request item.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  cmd;
		logic [7:0]  flags;
		logic [23:0] address;
		logic [15:0] data_length;
	} trace_in_t;

	// One result item.
	typedef struct packed {
		logic                   event_valid;
		logic [7:0]             ev_cmd;
		logic [7:0]             ev_flags;
		logic [23:0]            ev_address;
		logic [15:0]            ev_length;
		logic                   last;
		logic [COUNT_OUT_W-1:0] stored_count;
		logic                   armed;
	} trace_out_t;

	// One stored event.
	typedef struct packed {
		logic [15:0] length;
		logic [23:0] address;
		logic [7:0]  flags;
		logic [7:0]  cmd;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/oetb_mem.sv @@
// Event ring storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
module oetb_mem #(
	parameter int DEPTH = oetb_pkg::EVENT_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  oetb_pkg::entry_t     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output oetb_pkg::entry_t     rdata
);
	import oetb_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// Write one entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry; hold the data between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/oetb_ctrl.sv @@
// Request decode, ring pointers, dump sequencer and result register.
`timescale 1ns / 1ps
module oetb_ctrl #(
	parameter int EVENT_DEPTH = oetb_pkg::EVENT_DEPTH_DEF,
	parameter int SLOT_W      = $clog2(EVENT_DEPTH),
	parameter int CNT_W       = $clog2(EVENT_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  oetb_pkg::trace_in_t    req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output oetb_pkg::trace_out_t   rsp_data,
	output logic                   mem_we,
	output logic [SLOT_W-1:0]      mem_waddr,
	output oetb_pkg::entry_t       mem_wdata,
	output logic                   mem_re,
	output logic [SLOT_W-1:0]      mem_raddr,
	input  oetb_pkg::entry_t       mem_rdata
);
	import oetb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(EVENT_DEPTH - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(EVENT_DEPTH);

	state_t             state_q, state_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic [CNT_W-1:0]   total_q, total_d;
	logic               armed_q, armed_d;
	logic [SLOT_W-1:0]  rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0]   dump_n_q, dump_n_d;
	logic [CNT_W-1:0]   issue_cnt_q, issue_cnt_d;
	logic               rd_pend_s1, rd_pend_d;
	logic               rd_last_s1, rd_last_d;
	logic               out_valid_q, out_valid_d;
	trace_out_t         out_q, out_d;

	logic               load_out;
	logic               accept;
	logic               move;
	logic               rd_issue;

	// Output register is free when empty or being taken.
	assign load_out  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !load_out;
	assign accept    = req_valid && !req_stall;

	// Move read data to the output; issue the next read behind it.
	assign move      = (state_q == ST_DUMP) && rd_pend_s1 && load_out;
	assign rd_issue  = (state_q == ST_DUMP) && (issue_cnt_q != dump_n_q)
		&& (!rd_pend_s1 || move);

	assign mem_re    = rd_issue;
	assign mem_raddr = rd_ptr_q;
	assign mem_waddr = slot_q;
	assign mem_wdata = '{length: req_data.data_length, address: req_data.address,
		flags: req_data.flags, cmd: req_data.cmd};
	assign mem_we    = accept && (req_data.kind == KIND_RECORD) && armed_q;

	// Decode requests and step the dump sequencer.
	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		total_d     = total_q;
		armed_d     = armed_q;
		rd_ptr_d    = rd_ptr_q;
		dump_n_d    = dump_n_q;
		issue_cnt_d = issue_cnt_q;
		rd_pend_d   = rd_pend_s1;
		rd_last_d   = rd_last_s1;
		out_valid_d = out_valid_q && rsp_stall;
		out_d       = out_q;

		if (accept) begin
			case (req_data.kind)
				KIND_RECORD: begin
					if (armed_q) begin
						slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
						if (total_q != CNT_FULL) begin
							total_d = total_q + CNT_W'(1);
						end
					end
				end
				KIND_ARM: begin
					armed_d = 1'b1;
				end
				KIND_DISARM: begin
					armed_d = 1'b0;
				end
				KIND_DUMP: begin
					armed_d = 1'b0;
					if (total_q != '0) begin
						state_d     = ST_DUMP;
						rd_ptr_d    = (total_q == CNT_FULL) ? slot_q : '0;
						dump_n_d    = total_q;
						issue_cnt_d = '0;
					end
					slot_d  = '0;
					total_d = '0;
				end
				KIND_CLEAR: begin
					slot_d  = '0;
					total_d = '0;
				end
				default: begin
				end
			endcase

			// Status result for everything but a dump with events.
			if (!((req_data.kind == KIND_DUMP) && (total_q != '0))) begin
				out_valid_d        = 1'b1;
				out_d              = '0;
				out_d.last         = 1'b1;
				out_d.stored_count = COUNT_OUT_W'(total_d);
				out_d.armed        = armed_d;
			end
		end

		if (rd_issue) begin
			rd_ptr_d    = (rd_ptr_q == SLOT_LAST) ? '0 : rd_ptr_q + SLOT_W'(1);
			issue_cnt_d = issue_cnt_q + CNT_W'(1);
			rd_pend_d   = 1'b1;
			rd_last_d   = (issue_cnt_q + CNT_W'(1)) == dump_n_q;
		end else if (move) begin
			rd_pend_d = 1'b0;
		end

		if (move) begin
			out_valid_d        = 1'b1;
			out_d.event_valid  = 1'b1;
			out_d.ev_cmd       = mem_rdata.cmd;
			out_d.ev_flags     = mem_rdata.flags;
			out_d.ev_address   = mem_rdata.address;
			out_d.ev_length    = mem_rdata.length;
			out_d.last         = rd_last_s1;
			out_d.stored_count = COUNT_OUT_W'(dump_n_q);
			out_d.armed        = 1'b0;
			if (rd_last_s1) begin
				state_d = ST_IDLE;
			end
		end
	end

	// Hold state, pointers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			total_q     <= '0;
			armed_q     <= 1'b0;
			rd_ptr_q    <= '0;
			dump_n_q    <= '0;
			issue_cnt_q <= '0;
			rd_pend_s1  <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q     <= state_d;
			slot_q      <= slot_d;
			total_q     <= total_d;
			armed_q     <= armed_d;
			rd_ptr_q    <= rd_ptr_d;
			dump_n_q    <= dump_n_d;
			issue_cnt_q <= issue_cnt_d;
			rd_pend_s1  <= rd_pend_d;
			rd_last_s1  <= rd_last_d;
			out_valid_q <= out_valid_d;
			out_q       <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Count never passes the ring depth.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_FULL)
		else $error("event count above ring depth");

	// No ring write while a dump reads it out.
	a_no_write_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> !mem_we)
		else $error("ring write during dump");

	// Pending read data exists only inside a dump.
	a_pend_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == ST_DUMP))
		else $error("read data pending outside dump");

	// Reads issued never exceed the dumped count.
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (issue_cnt_q <= dump_n_q))
		else $error("dump read count overrun");

	// The last dumped event ends the dump.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(move && rd_last_s1) |=> (state_q == ST_IDLE) && !rd_pend_s1)
		else $error("dump did not end after last event");

endmodule

@@ hw/rtl/overwriting_event_trace_buffer_top.sv @@
// Top level of the overwriting event trace buffer.
//
// Request channel (req_valid, req_stall, req_data) takes one item per cycle
// while req_stall is low: record, arm, disarm, dump or clear. A record is
// stored in a ring of EVENT_DEPTH entries while capture is armed; when
// full it overwrites the oldest entry. Result channel (rsp_valid, rsp_stall,
// rsp_data) carries one status result per request, except a dump of a
// non-empty buffer, which gives every stored event oldest first with last
// set on the final one. A status result is in the output register in the
// cycle after the request. Records, arm, disarm and clear sustain one
// request per cycle while rsp_stall stays low. During a dump req_stall stays
// high until the last event moves to the output register; the ring memory's
// single registered read port gives one event per cycle when rsp_stall
// stays low. A stalled result holds in the output register; outside a dump,
// req_stall rises only when that register is full and stalled.
// Reset clears pointers, count and the armed flag (capture starts disarmed);
// ring contents are not cleared, and no clearing pass is needed.
`timescale 1ns / 1ps
module overwriting_event_trace_buffer_top #(
	parameter int EVENT_DEPTH = oetb_pkg::EVENT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  oetb_pkg::trace_in_t  req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output oetb_pkg::trace_out_t rsp_data
);
	import oetb_pkg::*;

	localparam int SLOT_W = $clog2(EVENT_DEPTH);

	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	entry_t            mem_wdata;
	logic              mem_re;
	logic [SLOT_W-1:0] mem_raddr;
	entry_t            mem_rdata;

	// Control and sequencing.
	oetb_ctrl #(
		.EVENT_DEPTH(EVENT_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Event ring.
	oetb_mem #(
		.DEPTH(EVENT_DEPTH),
		.AW   (SLOT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ bench/oetb_checker.sv @@
// Trace buffer checker: watches both channels, predicts results and compares them.
`timescale 1ns / 1ps
module oetb_checker #(
	parameter int EVENT_DEPTH = oetb_pkg::EVENT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  oetb_pkg::trace_in_t  req_data,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  oetb_pkg::trace_out_t rsp_data,
	output int                   mismatch_count,
	output int                   pending_results
);
	import oetb_pkg::*;

	// Predicted trace ring and its pointers
	entry_t                 trace_ring [EVENT_DEPTH];
	int                     ring_wr = 0;
	logic [COUNT_OUT_W-1:0] ring_fill = '0;
	logic                   capture_armed = 1'b0;

	// Results still owed by the block, oldest first
	trace_out_t             owed_results [$];
	trace_out_t             want;
	int                     fault_total = 0;
	int                     owed_total = 0;

	assign mismatch_count  = fault_total;
	assign pending_results = owed_total;

	// Compare one field and log a difference
	function automatic void check_field(string field, logic [63:0] exp_val,
		logic [63:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, field, exp_val, got_val);
			fault_total++;
		end
	endfunction

	// Work out every result one request causes and queue them
	task automatic predict_request(input trace_in_t req);
		trace_out_t res;
		entry_t     ev;
		int         first;
		bit         dumped;
		dumped = 1'b0;
		case (req.kind)
		KIND_RECORD: begin
			if (capture_armed) begin
				ev.cmd     = req.cmd;
				ev.flags   = req.flags;
				ev.address = req.address;
				ev.length  = req.data_length;
				trace_ring[ring_wr] = ev;
				ring_wr = (ring_wr + 1) % EVENT_DEPTH;
				if (ring_fill < EVENT_DEPTH)
					ring_fill++;
			end
		end
		KIND_ARM: capture_armed = 1'b1;
		KIND_DISARM: capture_armed = 1'b0;
		KIND_DUMP: begin
			capture_armed = 1'b0;
			if (ring_fill != 0) begin
				// oldest entry sits at the write pointer once the ring has wrapped
				first = (ring_fill == EVENT_DEPTH) ? ring_wr : 0;
				for (int i = 0; i < ring_fill; i++) begin
					ev                 = trace_ring[(first + i) % EVENT_DEPTH];
					res.event_valid    = 1'b1;
					res.ev_cmd         = ev.cmd;
					res.ev_flags       = ev.flags;
					res.ev_address     = ev.address;
					res.ev_length      = ev.length;
					res.last           = (i + 1 == ring_fill);
					res.stored_count   = ring_fill;
					res.armed          = 1'b0;
					owed_results.push_back(res);
				end
				ring_wr   = 0;
				ring_fill = '0;
				dumped    = 1'b1;
			end
		end
		KIND_CLEAR: begin
			ring_wr   = 0;
			ring_fill = '0;
		end
		default: ;
		endcase
		// one status result for everything but a dump that emitted events
		if (!dumped) begin
			res              = '0;
			res.last         = 1'b1;
			res.stored_count = ring_fill;
			res.armed        = capture_armed;
			owed_results.push_back(res);
		end
	endtask

	// Check results, then predict from the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_results.delete();
			ring_wr       = 0;
			ring_fill     = '0;
			capture_armed = 1'b0;
			owed_total    = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_results.size() == 0) begin
					$display("%0t ns: result expected none, got %h", $time, rsp_data);
					fault_total++;
				end else begin
					want = owed_results.pop_front();
					check_field("event_valid", 64'(want.event_valid),
						64'(rsp_data.event_valid));
					check_field("ev_cmd", 64'(want.ev_cmd), 64'(rsp_data.ev_cmd));
					check_field("ev_flags", 64'(want.ev_flags), 64'(rsp_data.ev_flags));
					check_field("ev_address", 64'(want.ev_address),
						64'(rsp_data.ev_address));
					check_field("ev_length", 64'(want.ev_length),
						64'(rsp_data.ev_length));
					check_field("last", 64'(want.last), 64'(rsp_data.last));
					check_field("stored_count", 64'(want.stored_count),
						64'(rsp_data.stored_count));
					check_field("armed", 64'(want.armed), 64'(rsp_data.armed));
				end
			end
			if (req_valid && !req_stall)
				predict_request(req_data);
			owed_total = owed_results.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the trace buffer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import oetb_pkg::*;

	localparam int ITEM_TARGET = 230;
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_LIMIT = 20000;

	// Kind codes the block treats as no-ops
	localparam logic [2:0] KIND_SPARE_A = 3'd5;
	localparam logic [2:0] KIND_SPARE_B = 3'd6;
	localparam logic [2:0] KIND_SPARE_C = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	trace_in_t  req_data = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	trace_out_t rsp_data;
	int         mismatch_count;
	int         pending_results;

	int         req_idle_pct = 11;
	int         rsp_idle_pct = 55;
	int         issued = 0;
	int         taken_count = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;

	overwriting_event_trace_buffer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	oetb_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_data        (req_data),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp_data        (rsp_data),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Count requests taken by the block
	always @(posedge clk) begin
		if (req_valid && !req_stall)
			taken_count <= taken_count + 1;
	end

	// Stall results at random; once, hold off long enough to back up the requests
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && taken_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	function automatic trace_in_t bus_req(logic [2:0] kind, logic [7:0] cmd,
		logic [7:0] flags, logic [23:0] address, logic [15:0] data_length);
		trace_in_t r;
		r.kind        = kind;
		r.cmd         = cmd;
		r.flags       = flags;
		r.address     = address;
		r.data_length = data_length;
		return r;
	endfunction

	function automatic trace_in_t rand_req(logic [2:0] kind);
		return bus_req(kind, 8'($urandom), 8'($urandom), 24'($urandom), 16'($urandom));
	endfunction

	// Offer one request after a random gap and hold it until taken
	task automatic send_req(input trace_in_t item);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		do @(posedge clk); while (req_stall);
		issued++;
	endtask

	// Stop offering and wait for every owed result, then let the block settle
	task automatic wait_drained();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending_results != 0 && waited < DRAIN_LIMIT);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int run_len;
		int phase;
		int new_phase;
		bit long_done;
		phase     = 0;
		long_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dump, ignored record, spare kinds, field extremes
		send_req(rand_req(KIND_DUMP));
		send_req(bus_req(KIND_RECORD, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF));
		send_req(rand_req(KIND_SPARE_A));
		send_req(rand_req(KIND_SPARE_B));
		send_req(bus_req(KIND_SPARE_C, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF));
		send_req(rand_req(KIND_DISARM));
		send_req(rand_req(KIND_ARM));
		send_req(bus_req(KIND_RECORD, 8'h00, 8'h00, 24'h000000, 16'h0000));
		send_req(bus_req(KIND_RECORD, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF));
		send_req(bus_req(KIND_RECORD, 8'hA5, 8'h5A, 24'h800001, 16'h8000));
		send_req(rand_req(KIND_ARM));
		send_req(rand_req(KIND_DUMP));
		// record right after a dump finds capture disarmed
		send_req(rand_req(KIND_RECORD));
		send_req(rand_req(KIND_ARM));
		send_req(rand_req(KIND_RECORD));
		send_req(rand_req(KIND_RECORD));
		// clear empties the ring but keeps capture armed
		send_req(bus_req(KIND_CLEAR, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF));
		send_req(rand_req(KIND_RECORD));
		send_req(rand_req(KIND_DISARM));
		send_req(rand_req(KIND_RECORD));
		send_req(rand_req(KIND_DUMP));
		send_req(rand_req(KIND_DUMP));
		send_req(bus_req(KIND_CLEAR, 8'h00, 8'h00, 24'h000000, 16'h0000));
		wait_drained();

		// Random capture sessions with noise between them
		while (issued < ITEM_TARGET) begin
			new_phase = (issued >= 160) ? 2 : (issued >= 80) ? 1 : 0;
			if (new_phase != phase) begin
				wait_drained();
				phase = new_phase;
				req_idle_pct = (phase == 1) ? 55 : 0;
				rsp_idle_pct = (phase == 1) ? 11 : 0;
			end
			if ($urandom_range(99) < 80) begin
				send_req(rand_req(KIND_ARM));
				// first session runs longer than the ring depth so the oldest entries can get overwritten
				if (!long_done)
					run_len = EVENT_DEPTH_DEF + $urandom_range(1, 12);
				else if ($urandom_range(9) == 0)
					run_len = $urandom_range(30, 70);
				else
					run_len = $urandom_range(0, 10);
				// keep the total close to the item target
				if (run_len > ITEM_TARGET - issued)
					run_len = ITEM_TARGET - issued;
				long_done = 1'b1;
				repeat (run_len) begin
					if ($urandom_range(99) < 8)
						send_req(rand_req(3'($urandom_range(0, 7))));
					else
						send_req(rand_req(KIND_RECORD));
				end
				send_req(rand_req(KIND_DUMP));
			end else begin
				send_req(rand_req(3'($urandom_range(0, 7))));
			end
		end

		wait_drained();
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("overwriting_event_trace_buffer_top: match");
		end else begin
			$display("overwriting_event_trace_buffer_top: mismatch");
		end
		$finish;
	end

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("overwriting_event_trace_buffer_top: mismatch");
		$finish;
	end

endmodule
